// ===== design/gtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtsc_pkg
// Shared types and constants for the GeneralizedTime syntax checker.
// ----------------------------------------------------------------------------
package gtsc_pkg;

  // Grammar positions: what the parser expects next.
  typedef enum logic [4:0] {
    POS_START      = 5'd0,
    POS_CENT2      = 5'd1,
    POS_YEAR1      = 5'd2,
    POS_YEAR2      = 5'd3,
    POS_MON1       = 5'd4,
    POS_MON_0X     = 5'd5,
    POS_MON_1X     = 5'd6,
    POS_DAY1       = 5'd7,
    POS_DAY_0X     = 5'd8,
    POS_DAY_12X    = 5'd9,
    POS_DAY_3X     = 5'd10,
    POS_HOUR1      = 5'd11,
    POS_HOUR_01X   = 5'd12,
    POS_HOUR_2X    = 5'd13,
    POS_HOURED     = 5'd14,
    POS_MIN2       = 5'd15,
    POS_MINUTED    = 5'd16,
    POS_SEC2       = 5'd17,
    POS_LEAP2      = 5'd18,
    POS_SECONDED   = 5'd19,
    POS_FRAC_FIRST = 5'd20,
    POS_FRAC_MORE  = 5'd21,
    POS_ZONE_HOUR1 = 5'd22,
    POS_ZONE_HOURB = 5'd23,
    POS_ZONE_HOURC = 5'd24,
    POS_ZONE_HOURD = 5'd25,
    POS_ZONE_MIN2  = 5'd26,
    POS_DONE       = 5'd27
  } pos_t;

  // ASCII codes used by the grammar.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Result of one grammar transition.
  typedef struct packed {
    logic ok;
    pos_t pos;
  } step_t;

  function automatic logic in_span(input logic [7:0] c, input logic [7:0] lo,
                                   input logic [7:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return in_span(c, CH_0, CH_9);
  endfunction

endpackage

// ===== design/gtsc_next.sv =====
// ----------------------------------------------------------------------------
// gtsc_next
// Grammar transition: next parse position for one byte, or a mismatch.
// ----------------------------------------------------------------------------
module gtsc_next (
  input  logic [7:0]           char_byte,
  input  gtsc_pkg::pos_t       pos,
  output gtsc_pkg::step_t      step
);

  logic             zone_start;
  logic             frac_start;
  gtsc_pkg::step_t  tail;
  gtsc_pkg::step_t  tail_nf;

  // A time zone may start wherever the optional parts may end; a fraction
  // may start there too, unless we are already inside one.
  always_comb begin
    zone_start = (char_byte == gtsc_pkg::CH_PLUS) || (char_byte == gtsc_pkg::CH_MINUS);
    frac_start = (char_byte == gtsc_pkg::CH_DOT) || (char_byte == gtsc_pkg::CH_COMMA);
    tail_nf.ok  = 1'b1;
    tail_nf.pos = gtsc_pkg::POS_START;
    if (char_byte == gtsc_pkg::CH_Z) begin
      tail_nf.pos = gtsc_pkg::POS_DONE;
    end else if (zone_start) begin
      tail_nf.pos = gtsc_pkg::POS_ZONE_HOUR1;
    end else begin
      tail_nf.ok = 1'b0;
    end
    tail = tail_nf;
    if (frac_start) begin
      tail.ok  = 1'b1;
      tail.pos = gtsc_pkg::POS_FRAC_FIRST;
    end
  end

  always_comb begin
    step.ok  = 1'b0;
    step.pos = gtsc_pkg::POS_START;
    case (pos)
      gtsc_pkg::POS_START, gtsc_pkg::POS_CENT2,
      gtsc_pkg::POS_YEAR1, gtsc_pkg::POS_YEAR2: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::pos_t'(pos + 5'd1);
      end
      gtsc_pkg::POS_MON1: begin
        step.ok  = (char_byte == gtsc_pkg::CH_0) || (char_byte == gtsc_pkg::CH_1);
        step.pos = (char_byte == gtsc_pkg::CH_0) ? gtsc_pkg::POS_MON_0X
                                                 : gtsc_pkg::POS_MON_1X;
      end
      gtsc_pkg::POS_MON_0X: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_1, gtsc_pkg::CH_9);
        step.pos = gtsc_pkg::POS_DAY1;
      end
      gtsc_pkg::POS_MON_1X: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_2);
        step.pos = gtsc_pkg::POS_DAY1;
      end
      gtsc_pkg::POS_DAY1: begin
        step.ok = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_3);
        if (char_byte == gtsc_pkg::CH_0) begin
          step.pos = gtsc_pkg::POS_DAY_0X;
        end else if (char_byte == gtsc_pkg::CH_3) begin
          step.pos = gtsc_pkg::POS_DAY_3X;
        end else begin
          step.pos = gtsc_pkg::POS_DAY_12X;
        end
      end
      gtsc_pkg::POS_DAY_0X: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_1, gtsc_pkg::CH_9);
        step.pos = gtsc_pkg::POS_HOUR1;
      end
      gtsc_pkg::POS_DAY_12X: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::POS_HOUR1;
      end
      gtsc_pkg::POS_DAY_3X: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_1);
        step.pos = gtsc_pkg::POS_HOUR1;
      end
      gtsc_pkg::POS_HOUR1: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_2);
        step.pos = (char_byte == gtsc_pkg::CH_2) ? gtsc_pkg::POS_HOUR_2X
                                                 : gtsc_pkg::POS_HOUR_01X;
      end
      gtsc_pkg::POS_HOUR_01X: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::POS_HOURED;
      end
      gtsc_pkg::POS_HOUR_2X: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_3);
        step.pos = gtsc_pkg::POS_HOURED;
      end
      gtsc_pkg::POS_HOURED: begin
        if (gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_5)) begin
          step.ok  = 1'b1;
          step.pos = gtsc_pkg::POS_MIN2;
        end else begin
          step = tail;
        end
      end
      gtsc_pkg::POS_MIN2: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::POS_MINUTED;
      end
      gtsc_pkg::POS_MINUTED: begin
        if (gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_5)) begin
          step.ok  = 1'b1;
          step.pos = gtsc_pkg::POS_SEC2;
        end else if (char_byte == gtsc_pkg::CH_6) begin
          step.ok  = 1'b1;
          step.pos = gtsc_pkg::POS_LEAP2;
        end else begin
          step = tail;
        end
      end
      gtsc_pkg::POS_SEC2: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::POS_SECONDED;
      end
      gtsc_pkg::POS_LEAP2: begin
        step.ok  = (char_byte == gtsc_pkg::CH_0);
        step.pos = gtsc_pkg::POS_SECONDED;
      end
      gtsc_pkg::POS_SECONDED: begin
        step = tail;
      end
      gtsc_pkg::POS_FRAC_FIRST: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::POS_FRAC_MORE;
      end
      gtsc_pkg::POS_FRAC_MORE: begin
        if (gtsc_pkg::is_dig(char_byte)) begin
          step.ok  = 1'b1;
          step.pos = gtsc_pkg::POS_FRAC_MORE;
        end else begin
          step = tail_nf;
        end
      end
      gtsc_pkg::POS_ZONE_HOUR1: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_2);
        step.pos = (char_byte == gtsc_pkg::CH_2) ? gtsc_pkg::POS_ZONE_HOURC
                                                 : gtsc_pkg::POS_ZONE_HOURB;
      end
      gtsc_pkg::POS_ZONE_HOURB: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::POS_ZONE_HOURD;
      end
      gtsc_pkg::POS_ZONE_HOURC: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_3);
        step.pos = gtsc_pkg::POS_ZONE_HOURD;
      end
      gtsc_pkg::POS_ZONE_HOURD: begin
        step.ok  = gtsc_pkg::in_span(char_byte, gtsc_pkg::CH_0, gtsc_pkg::CH_5);
        step.pos = gtsc_pkg::POS_ZONE_MIN2;
      end
      gtsc_pkg::POS_ZONE_MIN2: begin
        step.ok  = gtsc_pkg::is_dig(char_byte);
        step.pos = gtsc_pkg::POS_DONE;
      end
      default: begin
        // Anything after the zone is a mismatch.
        step.ok  = 1'b0;
        step.pos = gtsc_pkg::POS_START;
      end
    endcase
  end

endmodule

// ===== design/generalized_time_syntax_checker_top.sv =====
// ----------------------------------------------------------------------------
// generalized_time_syntax_checker_top
// Streams a GeneralizedTime value one byte per beat and gives one verdict
// beat on the byte marked last.
// ----------------------------------------------------------------------------
//  channel | direction | payload                 | handshake
//  in_     | input     | char_byte, last_byte    | in_valid / in_stall
//  out_    | output    | value_ok                | out_valid / out_stall
//
//  One byte is accepted per cycle unless in_stall holds it; after its last
//  byte is accepted a verdict passes the input register, then the result register.
//  The parse position and failure flag are updated in the single step
//  between the two registers and rearm after every last byte.
//  rst_n is synchronous and active low and empties both registers.
//  A waiting verdict holds only bytes marked last; other bytes keep flowing.
// ----------------------------------------------------------------------------
module generalized_time_syntax_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_value_ok
);

  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_char_r;
  logic            s1_last_r;
  gtsc_pkg::pos_t  pos_r, pos_nxt;
  logic            failed_r, failed_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_ok_r, out_ok_nxt;
  logic            proc;
  logic            in_take;
  gtsc_pkg::step_t step;

  gtsc_next u_next (
    .char_byte (s1_char_r),
    .pos       (pos_r),
    .step      (step)
  );

  // A byte that is not last produces no verdict, so it never waits on the
  // result register.
  assign proc     = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !proc);
    pos_nxt       = pos_r;
    failed_nxt    = failed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    if (proc) begin
      if (!failed_r) begin
        if (step.ok) begin
          pos_nxt = step.pos;
        end else begin
          failed_nxt = 1'b1;
        end
      end
      if (s1_last_r) begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = !failed_nxt && ((pos_nxt == gtsc_pkg::POS_DONE) ||
                                        (pos_nxt == gtsc_pkg::POS_ZONE_HOURD));
        pos_nxt       = gtsc_pkg::POS_START;
        failed_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= gtsc_pkg::POS_START;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_byte;
      s1_last_r <= in_last_byte;
    end
    out_ok_r <= out_ok_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value_ok = out_ok_r;

  // The parser rearms after every last byte.
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> (pos_r == gtsc_pkg::POS_START) && !failed_r)
    else $error("parser did not rearm after last byte");

  // A mismatch stays sticky until the value ends.
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r && !(proc && s1_last_r) |=> failed_r)
    else $error("failure flag dropped inside a value");

  // Every processed last byte leaves a verdict in the result register.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> out_valid_r)
    else $error("last byte produced no verdict");

  // The parse position never leaves the grammar.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= gtsc_pkg::POS_DONE)
    else $error("parse position out of range");

endmodule

// ===== bench/generalized_time_syntax_checker_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generalized_time_syntax_checker_top_test
// Streams GeneralizedTime values through the checker byte by byte. A short
// table of hand-written values comes first, then random values, mostly
// well-formed with random content and some broken or pure noise. Each verdict
// beat is compared with the table's verdict, else with a bench byte-level parser,
// under several sender and receiver idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module generalized_time_syntax_checker_top_test;

  localparam int TABLE_ROWS = 25;
  localparam int BY_PARSER = -1;
  // Placeholders in the table text for bytes that a string cannot hold well.
  localparam logic [7:0] MARK_FF = 8'h23;
  localparam logic [7:0] MARK_00 = 8'h21;
  localparam logic [7:0] MARK_80 = 8'h7E;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic       typed_ok;
  } text_byte_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_value_ok;

  text_byte_t text_q[$];
  text_byte_t cur_byte;
  logic       verdict_q[$];
  logic [7:0] draft[$];
  int         bytes_queued = 0;
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold = 1'b0;
  logic       hold_on = 1'b0;

  gtsc_pkg::pos_t parse_pos = gtsc_pkg::POS_START;
  logic           parse_failed = 1'b0;

  string      table_text [TABLE_ROWS] = '{
    "19700101000000Z",
    "99991231235960.999+2359",
    "00000101000000,0-0000",
    "2024010100Z",
    "202401010Z",
    "2024010100",
    "2024010100+05",
    "2024010100+0",
    "2024130100Z",
    "2024003100Z",
    "2024013200Z",
    "2024010124Z",
    "202401011260Z",
    "20240101123461Z",
    "2024010112.5Z",
    "2024010112.Z",
    "2024010112.55",
    "2024010112ZZ",
    "2024010112+01300",
    "2024010112+2400",
    "2024010112-2360",
    "Z",
    "2024#10100Z",
    "~024010100!",
    "20991231235959.123456789-1130"
  };
  int         table_verdict [TABLE_ROWS] = '{
    1, 1, 1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    BY_PARSER
  };

  generalized_time_syntax_checker_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char_byte(in_char_byte),
    .in_last_byte(in_last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value_ok(out_value_ok)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("generalized_time_syntax_checker_top regression: fail");
    $finish;
  end

  function automatic logic ascii_digit(input logic [7:0] c);
    return c >= gtsc_pkg::CH_0 && c <= gtsc_pkg::CH_9;
  endfunction

  function automatic logic byte_between(input logic [7:0] c, input logic [7:0] lo,
                                        input logic [7:0] hi);
    return c >= lo && c <= hi;
  endfunction

  // Fraction or zone start, where the optional parts of the time may end.
  function automatic logic tail_move(input logic [7:0] c, input logic frac_ok,
                                     output gtsc_pkg::pos_t nxt);
    nxt = gtsc_pkg::POS_START;
    if (frac_ok && (c == gtsc_pkg::CH_DOT || c == gtsc_pkg::CH_COMMA))
      nxt = gtsc_pkg::POS_FRAC_FIRST;
    else if (c == gtsc_pkg::CH_Z) nxt = gtsc_pkg::POS_DONE;
    else if (c == gtsc_pkg::CH_PLUS || c == gtsc_pkg::CH_MINUS)
      nxt = gtsc_pkg::POS_ZONE_HOUR1;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic grammar_move(input gtsc_pkg::pos_t p, input logic [7:0] c,
                                        output gtsc_pkg::pos_t nxt);
    logic ok;
    ok = 1'b1;
    nxt = p;
    case (p)
      gtsc_pkg::POS_START, gtsc_pkg::POS_CENT2,
      gtsc_pkg::POS_YEAR1, gtsc_pkg::POS_YEAR2: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::pos_t'(p + 5'd1);
      end
      gtsc_pkg::POS_MON1: begin
        if (c == gtsc_pkg::CH_0) nxt = gtsc_pkg::POS_MON_0X;
        else if (c == gtsc_pkg::CH_1) nxt = gtsc_pkg::POS_MON_1X;
        else ok = 1'b0;
      end
      gtsc_pkg::POS_MON_0X: begin
        ok = byte_between(c, gtsc_pkg::CH_1, gtsc_pkg::CH_9);
        nxt = gtsc_pkg::POS_DAY1;
      end
      gtsc_pkg::POS_MON_1X: begin
        ok = byte_between(c, gtsc_pkg::CH_0, gtsc_pkg::CH_2);
        nxt = gtsc_pkg::POS_DAY1;
      end
      gtsc_pkg::POS_DAY1: begin
        if (c == gtsc_pkg::CH_0) nxt = gtsc_pkg::POS_DAY_0X;
        else if (c == gtsc_pkg::CH_1 || c == gtsc_pkg::CH_2) nxt = gtsc_pkg::POS_DAY_12X;
        else if (c == gtsc_pkg::CH_3) nxt = gtsc_pkg::POS_DAY_3X;
        else ok = 1'b0;
      end
      gtsc_pkg::POS_DAY_0X: begin
        ok = byte_between(c, gtsc_pkg::CH_1, gtsc_pkg::CH_9);
        nxt = gtsc_pkg::POS_HOUR1;
      end
      gtsc_pkg::POS_DAY_12X: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::POS_HOUR1;
      end
      gtsc_pkg::POS_DAY_3X: begin
        ok = byte_between(c, gtsc_pkg::CH_0, gtsc_pkg::CH_1);
        nxt = gtsc_pkg::POS_HOUR1;
      end
      gtsc_pkg::POS_HOUR1: begin
        if (c == gtsc_pkg::CH_0 || c == gtsc_pkg::CH_1) nxt = gtsc_pkg::POS_HOUR_01X;
        else if (c == gtsc_pkg::CH_2) nxt = gtsc_pkg::POS_HOUR_2X;
        else ok = 1'b0;
      end
      gtsc_pkg::POS_HOUR_01X: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::POS_HOURED;
      end
      gtsc_pkg::POS_HOUR_2X: begin
        ok = byte_between(c, gtsc_pkg::CH_0, gtsc_pkg::CH_3);
        nxt = gtsc_pkg::POS_HOURED;
      end
      gtsc_pkg::POS_HOURED: begin
        if (byte_between(c, gtsc_pkg::CH_0, gtsc_pkg::CH_5)) nxt = gtsc_pkg::POS_MIN2;
        else ok = tail_move(c, 1'b1, nxt);
      end
      gtsc_pkg::POS_MIN2: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::POS_MINUTED;
      end
      gtsc_pkg::POS_MINUTED: begin
        if (byte_between(c, gtsc_pkg::CH_0, gtsc_pkg::CH_5)) nxt = gtsc_pkg::POS_SEC2;
        else if (c == gtsc_pkg::CH_6) nxt = gtsc_pkg::POS_LEAP2;
        else ok = tail_move(c, 1'b1, nxt);
      end
      gtsc_pkg::POS_SEC2: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::POS_SECONDED;
      end
      gtsc_pkg::POS_LEAP2: begin
        ok = (c == gtsc_pkg::CH_0);
        nxt = gtsc_pkg::POS_SECONDED;
      end
      gtsc_pkg::POS_SECONDED: ok = tail_move(c, 1'b1, nxt);
      gtsc_pkg::POS_FRAC_FIRST: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::POS_FRAC_MORE;
      end
      gtsc_pkg::POS_FRAC_MORE: begin
        if (!ascii_digit(c)) ok = tail_move(c, 1'b0, nxt);
      end
      gtsc_pkg::POS_ZONE_HOUR1: begin
        if (c == gtsc_pkg::CH_0 || c == gtsc_pkg::CH_1) nxt = gtsc_pkg::POS_ZONE_HOURB;
        else if (c == gtsc_pkg::CH_2) nxt = gtsc_pkg::POS_ZONE_HOURC;
        else ok = 1'b0;
      end
      gtsc_pkg::POS_ZONE_HOURB: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::POS_ZONE_HOURD;
      end
      gtsc_pkg::POS_ZONE_HOURC: begin
        ok = byte_between(c, gtsc_pkg::CH_0, gtsc_pkg::CH_3);
        nxt = gtsc_pkg::POS_ZONE_HOURD;
      end
      gtsc_pkg::POS_ZONE_HOURD: begin
        ok = byte_between(c, gtsc_pkg::CH_0, gtsc_pkg::CH_5);
        nxt = gtsc_pkg::POS_ZONE_MIN2;
      end
      gtsc_pkg::POS_ZONE_MIN2: begin
        ok = ascii_digit(c);
        nxt = gtsc_pkg::POS_DONE;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Feeds one accepted byte to the parser; returns 1 when a verdict is due.
  function automatic logic parse_byte(input logic [7:0] c, input logic last,
                                      output logic verdict);
    gtsc_pkg::pos_t nxt;
    verdict = 1'b0;
    if (!parse_failed) begin
      if (grammar_move(parse_pos, c, nxt)) parse_pos = nxt;
      else parse_failed = 1'b1;
    end
    if (!last) return 1'b0;
    // A zone may end after its hour, so that position accepts as well.
    verdict = !parse_failed && (parse_pos == gtsc_pkg::POS_DONE ||
                                parse_pos == gtsc_pkg::POS_ZONE_HOURD);
    parse_pos = gtsc_pkg::POS_START;
    parse_failed = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_fault(input string what, input logic want, input logic got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t ns: %s: expected value_ok=%b, got %b", $time, what, want, got);
  endtask

  // Sender: records the accepted beat, then offers the next byte or idles.
  always @(posedge clk) begin : drive_text
    logic verdict;
    if (in_valid && !in_stall) begin
      if (parse_byte(in_char_byte, in_last_byte, verdict))
        verdict_q.push_back(cur_byte.typed ? cur_byte.typed_ok : verdict);
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_byte = text_q.pop_front();
        in_valid <= 1'b1;
        in_char_byte <= cur_byte.ch;
        in_last_byte <= cur_byte.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= hold || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_verdict
    logic want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (verdict_q.size() == 0) begin
        report_fault("verdict with none pending", 1'bx, out_value_ok);
      end else begin
        want = verdict_q.pop_front();
        if (out_value_ok !== want) report_fault("verdict mismatch", want, out_value_ok);
      end
    end
  end

  // Long receiver hold-off so that waiting verdicts back up into the input.
  initial begin
    wait (hold_on);
    @(negedge clk);
    hold = 1'b1;
    repeat (300) @(negedge clk);
    hold = 1'b0;
  end

  task automatic put_pair(input int v);
    draft.push_back(gtsc_pkg::CH_0 + 8'(v / 10));
    draft.push_back(gtsc_pkg::CH_0 + 8'(v % 10));
  endtask

  // A two-digit field, now and then outside its legal range.
  task automatic put_field(input int lo, input int hi);
    if ($urandom_range(99) < 8) put_pair($urandom_range(99));
    else put_pair($urandom_range(hi, lo));
  endtask

  task automatic queue_draft(input logic typed, input logic typed_ok);
    foreach (draft[i])
      text_q.push_back('{ch: draft[i], last: (i == draft.size() - 1),
                         typed: typed, typed_ok: typed_ok});
    bytes_queued += draft.size();
  endtask

  task automatic queue_random_value();
    int n;
    int cut;
    draft = {};
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(14, 1);
      repeat (n) draft.push_back(8'($urandom_range(255)));
    end else begin
      repeat (4) draft.push_back(gtsc_pkg::CH_0 + 8'($urandom_range(9)));
      put_field(1, 12);
      put_field(1, 31);
      put_field(0, 23);
      if ($urandom_range(99) < 70) begin
        put_field(0, 59);
        if ($urandom_range(99) < 60) begin
          if ($urandom_range(99) < 15) put_pair(60);
          else put_field(0, 59);
        end
      end
      if ($urandom_range(99) < 30) begin
        draft.push_back($urandom_range(1) ? gtsc_pkg::CH_DOT : gtsc_pkg::CH_COMMA);
        n = ($urandom_range(99) < 5) ? 0 : $urandom_range(5, 1);
        repeat (n) draft.push_back(gtsc_pkg::CH_0 + 8'($urandom_range(9)));
      end
      if ($urandom_range(2) == 0) begin
        draft.push_back(gtsc_pkg::CH_Z);
      end else begin
        draft.push_back($urandom_range(1) ? gtsc_pkg::CH_PLUS : gtsc_pkg::CH_MINUS);
        put_field(0, 23);
        if ($urandom_range(99) < 60) put_field(0, 59);
      end
      // Break about a quarter of the values: a wrong byte, a cut, or a tail.
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(2))
          0: draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
          1: begin
            cut = $urandom_range(draft.size() - 1, 1);
            while (draft.size() > cut) draft.delete(draft.size() - 1);
          end
          default: draft.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    queue_draft(1'b0, 1'b0);
  endtask

  task automatic drain_text();
    while (text_q.size() != 0 || in_valid) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
    int start;
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) queue_random_value();
    drain_text();
  endtask

  initial begin : main
    logic [7:0] c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < TABLE_ROWS; r++) begin
      draft = {};
      for (int i = 0; i < table_text[r].len(); i++) begin
        c = table_text[r][i];
        if (c == MARK_FF) c = 8'hFF;
        else if (c == MARK_00) c = 8'h00;
        else if (c == MARK_80) c = 8'h80;
        draft.push_back(c);
      end
      queue_draft(table_verdict[r] != BY_PARSER, table_verdict[r] == 1);
    end
    drain_text();

    run_phase(0, 0, 225);
    run_phase(56, 0, 225);
    run_phase(0, 56, 225);
    run_phase(13, 13, 225);
    @(negedge clk);
    hold_on = 1'b1;
    run_phase(0, 0, 100);

    recv_stall_pct = 0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("generalized_time_syntax_checker_top regression: pass");
    end else begin
      $display("generalized_time_syntax_checker_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gtsc_pkg.sv
design/gtsc_next.sv
design/generalized_time_syntax_checker_top.sv
bench/generalized_time_syntax_checker_top_test.sv
